[design/oahs_pkg.sv]
package oahs_pkg;

  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 9;
  localparam int LIMIT_W  = 9;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd102;
  localparam logic [COUNT_W-1:0] COUNT_SAT   = 9'h1FF;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_PRESENT  = 2'd1,
    ST_FULL     = 2'd2,
    ST_CLEARED  = 2'd3
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    capture;
    logic    hash_step;
    logic    rd_issue;
    logic    probe_adv;
    logic    write_slot;
    logic    sweep_en;
    logic    count_clear;
    logic    load_out;
    status_t out_status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic key_zero;
    logic hash_done;
    logic slot_valid;
    logic slot_match;
    logic last_step;
    logic sweep_last;
    logic out_free;
  } sts_t;

endpackage

[design/oahs_dp.sv]
module oahs_dp #(
  parameter int SLOT_COUNT = 256,
  parameter int KEY_BITS   = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  oahs_pkg::cmd_t                 cmd,
  output oahs_pkg::sts_t                 sts,
  input  logic [KEY_BITS-1:0]            in_key,
  input  logic                           cfg_wr,
  input  logic [oahs_pkg::LIMIT_W-1:0]   cfg_load_limit,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [oahs_pkg::STATUS_W-1:0]  out_status,
  output logic [oahs_pkg::COUNT_W-1:0]   out_entry_count,
  output logic                           out_over_load
);
  import oahs_pkg::*;

  localparam int  IDX_W  = $clog2(SLOT_COUNT);
  localparam int  STEP_W = $clog2(SLOT_COUNT + 1);
  localparam int  SUM_W  = STEP_W + 1;
  localparam int  NCHUNK = (KEY_BITS + 15) / 16;
  localparam int  KPAD_W = NCHUNK * 16;
  localparam int  HSTEPS = 2 * NCHUNK;
  localparam int  BCNT_W = $clog2(HSTEPS + 1);
  localparam int  EXT_W  = KEY_BITS + IDX_W;
  localparam int  CW     = (STEP_W > COUNT_W) ? STEP_W : COUNT_W;
  localparam bit  POW2   = (SLOT_COUNT & (SLOT_COUNT - 1)) == 0;
  localparam logic [31:0] MOD32 = 32'(SLOT_COUNT);
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / SLOT_COUNT);

  logic [KEY_BITS:0]    mem [SLOT_COUNT];
  logic [KEY_BITS:0]    rd_data_r;
  logic [KEY_BITS-1:0]  key_r;
  logic [KPAD_W-1:0]    ksh_r;
  logic [BCNT_W-1:0]    bcnt_r;
  logic                 hph_r;
  logic [31:0]          hx_r;
  logic [47:0]          hprod_r;
  logic [IDX_W-1:0]     idx_r;
  logic [STEP_W-1:0]    step_r;
  logic [IDX_W-1:0]     sweep_addr_r;
  logic [STEP_W-1:0]    count_r;
  logic [STEP_W-1:0]    count_nxt;
  logic [LIMIT_W-1:0]   load_limit_r;
  logic                 out_valid_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic [COUNT_W-1:0]   out_count_r;
  logic                 out_over_r;

  logic [EXT_W-1:0]     key_ext;
  logic [31:0]          hx_nxt;
  logic [15:0]          hq;
  logic [31:0]          hrem;
  logic [IDX_W-1:0]     rem_nxt;
  logic [SUM_W-1:0]     probe_sum;
  logic [IDX_W-1:0]     probe_nxt;
  logic [CW-1:0]        cnt_ext;

  assign key_ext = EXT_W'(in_key);

  // Key mod SLOT_COUNT, sixteen key bits per two steps, top chunk first. The
  // partial remainder and the next chunk form x; the quotient estimate taken
  // from a constant reciprocal is at most one short, so a single compare and
  // subtract leaves the true remainder.
  assign hx_nxt  = {16'(idx_r), ksh_r[KPAD_W-1 -: 16]};
  assign hq      = hprod_r[47:32];
  assign hrem    = hx_r - 32'(hq) * MOD32;
  assign rem_nxt = (hrem >= MOD32) ? IDX_W'(hrem - MOD32) : IDX_W'(hrem);

  // Triangular probing: slot i+1 is slot i plus (i+1), wrapped once.
  assign probe_sum = SUM_W'(idx_r) + SUM_W'(step_r) + SUM_W'(1);
  assign probe_nxt = (probe_sum >= SUM_W'(SLOT_COUNT)) ?
                     IDX_W'(probe_sum - SUM_W'(SLOT_COUNT)) : IDX_W'(probe_sum);

  always_comb begin
    if (cmd.count_clear) begin
      count_nxt = '0;
    end else if (cmd.write_slot) begin
      count_nxt = count_r + STEP_W'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  assign cnt_ext = CW'(count_nxt);

  assign sts.key_zero   = (in_key == '0);
  assign sts.hash_done  = (bcnt_r == '0);
  assign sts.slot_valid = rd_data_r[KEY_BITS];
  assign sts.slot_match = (rd_data_r[KEY_BITS-1:0] == key_r);
  assign sts.last_step  = (step_r == STEP_W'(SLOT_COUNT - 1));
  assign sts.sweep_last = (sweep_addr_r == IDX_W'(SLOT_COUNT - 1));
  assign sts.out_free   = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.sweep_en) begin
      mem[sweep_addr_r] <= '0;
    end else if (cmd.write_slot) begin
      mem[idx_r] <= {1'b1, key_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_data_r <= mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      key_r  <= in_key;
      ksh_r  <= KPAD_W'(in_key);
      bcnt_r <= POW2 ? '0 : BCNT_W'(HSTEPS);
      hph_r  <= 1'b0;
      idx_r  <= POW2 ? key_ext[IDX_W-1:0] : '0;
      step_r <= '0;
    end else if (cmd.hash_step) begin
      if (!hph_r) begin
        hx_r    <= hx_nxt;
        hprod_r <= 48'(64'(hx_nxt) * 64'(RECIP));
        ksh_r   <= ksh_r << 16;
      end else begin
        idx_r   <= rem_nxt;
      end
      hph_r  <= !hph_r;
      bcnt_r <= bcnt_r - BCNT_W'(1);
    end else if (cmd.probe_adv) begin
      idx_r  <= probe_nxt;
      step_r <= step_r + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_addr_r <= '0;
      count_r      <= '0;
      load_limit_r <= LIMIT_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.sweep_en) begin
        sweep_addr_r <= sts.sweep_last ? '0 : sweep_addr_r + IDX_W'(1);
      end
      count_r <= count_nxt;
      if (cfg_wr) begin
        load_limit_r <= cfg_load_limit;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r <= cmd.out_status;
      out_count_r  <= (cnt_ext > CW'(COUNT_SAT)) ? COUNT_SAT : cnt_ext[COUNT_W-1:0];
      out_over_r   <= (cnt_ext > CW'(load_limit_r));
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;
  assign out_over_load   = out_over_r;

endmodule

[design/oahs_ctrl.sv]
module oahs_ctrl #(
  parameter int SLOT_COUNT = 256
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            in_operation,
  input  oahs_pkg::sts_t  sts,
  output oahs_pkg::cmd_t  cmd
);
  import oahs_pkg::*;

  localparam bit POW2 = (SLOT_COUNT & (SLOT_COUNT - 1)) == 0;

  typedef enum logic [6:0] {
    S_INIT = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_HASH = 7'b0000100,
    S_RD   = 7'b0001000,
    S_CMP  = 7'b0010000,
    S_CLR  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t  state_r, state_nxt;
  status_t code_r, code_nxt;
  logic    finish;
  status_t fin_code;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    code_nxt  = code_r;
    finish    = 1'b0;
    fin_code  = ST_INSERTED;
    unique case (state_r)
      S_INIT: begin
        cmd.sweep_en = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (in_operation == OP_CLEAR) begin
            state_nxt = S_CLR;
          end else if (sts.key_zero) begin
            code_nxt  = ST_PRESENT;
            state_nxt = S_DONE;
          end else begin
            state_nxt = POW2 ? S_RD : S_HASH;
          end
        end
      end
      S_HASH: begin
        if (sts.hash_done) begin
          state_nxt = S_RD;
        end else begin
          cmd.hash_step = 1'b1;
        end
      end
      S_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_CMP;
      end
      S_CMP: begin
        priority if (!sts.slot_valid) begin
          cmd.write_slot = 1'b1;
          finish         = 1'b1;
          fin_code       = ST_INSERTED;
        end else if (sts.slot_match) begin
          finish   = 1'b1;
          fin_code = ST_PRESENT;
        end else if (sts.last_step) begin
          finish   = 1'b1;
          fin_code = ST_FULL;
        end else begin
          cmd.probe_adv = 1'b1;
          state_nxt     = S_RD;
        end
      end
      S_CLR: begin
        cmd.sweep_en = 1'b1;
        if (sts.sweep_last) begin
          cmd.count_clear = 1'b1;
          finish          = 1'b1;
          fin_code        = ST_CLEARED;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out   = 1'b1;
          cmd.out_status = code_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Hand the result straight to the output register when it is free,
    // otherwise park the code and wait.
    if (finish) begin
      if (sts.out_free) begin
        cmd.load_out   = 1'b1;
        cmd.out_status = fin_code;
        state_nxt      = S_IDLE;
      end else begin
        code_nxt  = fin_code;
        state_nxt = S_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
  end

endmodule

[design/open_addressing_hash_set_insert.sv]
// Open-addressing set of nonzero keys with insert and clear. Each insert
// hashes the key by identity (key mod SLOT_COUNT) and probes slots along a
// triangular sequence: slot i+1 is slot i plus (i+1), which visits every
// slot when SLOT_COUNT is a power of two. Keys live in a single memory of
// SLOT_COUNT entries, each holding a valid bit and the key, with one port
// for the probe read and one for the write. Every probe is a read issue
// in S_RD followed by a compare of the registered read data in S_CMP.
// When SLOT_COUNT is not a power of two the key is first reduced sixteen
// bits at a time in S_HASH, with a load step and a reduce step for each
// sixteen bits. An insert of key zero stores nothing and reports
// ST_PRESENT. A clear sweeps the memory one entry per cycle. After
// reset the same sweep runs while in_stall is held high; configuration
// writes are taken at any time. A finished result sits in an output
// register, so the next item is taken while it waits on out_stall. The
// load limit register resets to 102; out_over_load is set when the count
// after the item is strictly above it. out_entry_count saturates at 511.
module open_addressing_hash_set_insert #(
  parameter int SLOT_COUNT = 256,
  parameter int KEY_BITS   = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_operation,
  input  logic [KEY_BITS-1:0]            in_key,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [oahs_pkg::STATUS_W-1:0]  out_status,
  output logic [oahs_pkg::COUNT_W-1:0]   out_entry_count,
  output logic                           out_over_load,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [oahs_pkg::LIMIT_W-1:0]   cfg_load_limit
);
  import oahs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The limit register can be written in any cycle.
  assign cfg_ready = 1'b1;

  oahs_ctrl #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .sts          (sts),
    .cmd          (cmd)
  );

  oahs_dp #(
    .SLOT_COUNT (SLOT_COUNT),
    .KEY_BITS   (KEY_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_key          (in_key),
    .cfg_wr          (cfg_valid && cfg_ready),
    .cfg_load_limit  (cfg_load_limit),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_entry_count (out_entry_count),
    .out_over_load   (out_over_load)
  );

endmodule
